// ----- src/dhss_pkg.sv -----
// ----------------------------------------------------------------------------
// dhss_pkg
// Shared widths, register indexes and reset values for the damped Hilbert
// slot search core.
// ----------------------------------------------------------------------------
package dhss_pkg;

  localparam int KEY_W   = 16;
  localparam int SLOT_W  = 12;
  localparam int COORD_W = 8;
  localparam int CNT_W   = 13;
  localparam int ORD_W   = 4;
  localparam int DAMP_W  = 9;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_SLOT_COUNT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CURVE_ORDER = 2'd1;
  localparam logic [IDX_W-1:0] REG_DAMPING     = 2'd2;

  localparam logic [CNT_W-1:0]  SLOT_COUNT_RST  = 13'd4096;
  localparam logic [ORD_W-1:0]  CURVE_ORDER_RST = 4'd8;
  localparam logic [DAMP_W-1:0] DAMPING_RST     = 9'd256;
  localparam logic [DAMP_W-1:0] DAMP_ONE        = 9'd256;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// ----- src/damped_hilbert_slot_search_core.sv -----
// ----------------------------------------------------------------------------
// damped_hilbert_slot_search_core
// Sorted Hilbert key table with damped nearest-key slot query.
// ----------------------------------------------------------------------------
// A key write and a query without target leave busy low, and a no-target
// result strobes on done in the next cycle. A query with target holds busy
// through HILB (one Hilbert round per cycle, for the effective curve order),
// DELTA, SCALE, WRAP, SRCH (each binary search step over the slot count is
// one read of the single-port key memory), NLOW and, when the found slot is
// above zero, NPREV.
// The result is on best_slot and damped_key for the one cycle that done is
// high and must be taken then.
module damped_hilbert_slot_search_core #(
  parameter int MAX_SLOTS = 4096,
  parameter int MAX_ORDER = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [dhss_pkg::SLOT_W-1:0]       slot,
  input  logic [dhss_pkg::KEY_W-1:0]        key,
  input  logic [dhss_pkg::COORD_W-1:0]      target_col,
  input  logic [dhss_pkg::COORD_W-1:0]      target_row,
  input  logic                              has_target,
  output logic                              done,
  output logic [dhss_pkg::SLOT_W-1:0]       best_slot,
  output logic [dhss_pkg::KEY_W-1:0]        damped_key,
  input  logic                              cfg_write,
  input  logic [dhss_pkg::IDX_W-1:0]        cfg_index,
  input  logic [dhss_pkg::CFG_W-1:0]        cfg_data
);

  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LVL_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam logic [16:0] SLOTS_L = 17'(MAX_SLOTS);
  localparam logic [dhss_pkg::ORD_W-1:0] ORDER_L = dhss_pkg::ORD_W'(MAX_ORDER);

  typedef enum logic [2:0] {
    IDLE, HILB, DELTA, SCALE, WRAP, SRCH, NLOW, NPREV
  } state_t;

  state_t state;

  logic [dhss_pkg::KEY_W-1:0] mem [0:MAX_SLOTS-1];
  logic [dhss_pkg::KEY_W-1:0] rdata;
  logic [ADDR_W-1:0]          ra;

  logic [dhss_pkg::CNT_W-1:0]  slot_count;
  logic [dhss_pkg::ORD_W-1:0]  curve_order;
  logic [dhss_pkg::DAMP_W-1:0] damping;

  logic [ADDR_W-1:0]           rd_addr;
  logic                        slot_ok;
  logic [dhss_pkg::SLOT_W-1:0] slot_reg;
  logic [LVL_W-1:0]            lvl;
  logic [dhss_pkg::COORD_W-1:0] hx, hy;
  logic [dhss_pkg::KEY_W-1:0]  hd;
  logic [dhss_pkg::KEY_W-1:0]  cur;
  logic [dhss_pkg::KEY_W-1:0]  mag;
  logic                        neg;
  logic [dhss_pkg::KEY_W-1:0]  scaled;
  logic [dhss_pkg::KEY_W-1:0]  target;
  logic [ADDR_W-1:0]           low, high, mid;
  logic [dhss_pkg::KEY_W-1:0]  key_low;

  // effective register values
  logic [dhss_pkg::ORD_W-1:0]  ord;
  logic [16:0]                 cnt;
  logic [ADDR_W-1:0]           high_init;
  logic [dhss_pkg::DAMP_W-1:0] dsat;
  logic [dhss_pkg::COORD_W-1:0] cmask;
  logic [16:0]                 total;
  logic [16:0]                 half;
  logic [dhss_pkg::KEY_W-1:0]  kmask;

  logic                        accept;
  logic [ADDR_W-1:0]           slot_addr;
  logic [ADDR_W+11:0]          slot_ext;
  logic                        slot_in;

  // datapath terms
  logic                        rx, ry;
  logic [dhss_pkg::KEY_W-1:0]  quad;
  logic [dhss_pkg::KEY_W-1:0]  cur_c;
  logic signed [17:0]          delta0, delta;
  logic [24:0]                 prod;
  logic signed [17:0]          sum0;
  logic [dhss_pkg::KEY_W-1:0]  damped_c;
  logic                        lt;
  logic [ADDR_W-1:0]           low_n, high_n, mid_n;
  logic [dhss_pkg::KEY_W-1:0]  d_low, d_prev;
  logic [ADDR_W+11:0]          best_ext;
  logic [ADDR_W+11:0]          prev_ext;

  always_comb begin
    if (curve_order == '0) ord = 4'd1;
    else if (curve_order > ORDER_L) ord = ORDER_L;
    else ord = curve_order;

    if (slot_count == '0) cnt = 17'd1;
    else if (17'(slot_count) > SLOTS_L) cnt = SLOTS_L;
    else cnt = 17'(slot_count);
    high_init = ADDR_W'(cnt - 17'd1);

    dsat  = (damping > dhss_pkg::DAMP_ONE) ? dhss_pkg::DAMP_ONE : damping;
    cmask = ~(8'hFF << ord);
    total = 17'd1 << {ord, 1'b0};
    half  = total >> 1;
    kmask = 16'(total - 17'd1);

    accept    = start && !busy;
    slot_ext  = {{ADDR_W{1'b0}}, slot};
    slot_addr = slot_ext[ADDR_W-1:0];
    slot_in   = {5'b0, slot} < SLOTS_L;
  end

  always_comb begin
    rx   = hx[lvl];
    ry   = hy[lvl];
    quad = 16'({rx, rx ^ ry}) << {lvl, 1'b0};

    cur_c  = slot_ok ? (rdata & kmask) : '0;
    delta0 = $signed({2'b0, hd}) - $signed({2'b0, cur_c});
    if (delta0 > $signed({1'b0, half})) delta = delta0 - $signed({1'b0, total});
    else if (delta0 < -$signed({1'b0, half})) delta = delta0 + $signed({1'b0, total});
    else delta = delta0;

    prod = 25'(mag) * 25'(dsat);

    sum0 = neg ? $signed({2'b0, cur}) - $signed({2'b0, scaled})
               : $signed({2'b0, cur}) + $signed({2'b0, scaled});
    if (sum0 < 18'sd0) damped_c = 16'(sum0 + $signed({1'b0, total}));
    else if (sum0 >= $signed({1'b0, total})) damped_c = 16'(sum0 - $signed({1'b0, total}));
    else damped_c = 16'(sum0);

    lt     = rdata < target;
    low_n  = lt ? mid + 1'b1 : low;
    high_n = lt ? high : mid;
    mid_n  = low_n + ((high_n - low_n) >> 1);

    d_low  = (key_low >= target) ? key_low - target : target - key_low;
    d_prev = (rdata >= target) ? rdata - target : target - rdata;
    best_ext = {12'b0, low};
    prev_ext = {12'b0, low - 1'b1};
  end

  always_comb begin
    ra = rd_addr;
    case (state)
      IDLE:  ra = slot_addr;
      WRAP:  ra = (high_init != '0) ? (high_init >> 1) : '0;
      SRCH:  ra = (low_n < high_n) ? mid_n : low_n;
      NLOW:  ra = low - 1'b1;
      default: ra = rd_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == dhss_pkg::CMD_WRITE && slot_in) begin
      mem[slot_addr] <= key;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= dhss_pkg::SLOT_COUNT_RST;
      curve_order <= dhss_pkg::CURVE_ORDER_RST;
      damping     <= dhss_pkg::DAMPING_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dhss_pkg::REG_SLOT_COUNT:  slot_count  <= cfg_data;
        dhss_pkg::REG_CURVE_ORDER: curve_order <= cfg_data[dhss_pkg::ORD_W-1:0];
        dhss_pkg::REG_DAMPING:     damping     <= cfg_data[dhss_pkg::DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (accept && cmd == dhss_pkg::CMD_QUERY) begin
            slot_reg <= slot;
            if (!has_target) begin
              done       <= 1'b1;
              best_slot  <= slot;
              damped_key <= '0;
            end else begin
              rd_addr <= slot_addr;
              slot_ok <= slot_in;
              lvl     <= LVL_W'(ord - 4'd1);
              hx      <= target_col & cmask;
              hy      <= target_row & cmask;
              hd      <= '0;
              state   <= HILB;
              busy    <= 1'b1;
            end
          end
        end
        HILB: begin
          hd <= hd | quad;
          if (!ry) begin
            hx <= rx ? (hy ^ cmask) : hy;
            hy <= rx ? (hx ^ cmask) : hx;
          end
          if (lvl == '0) state <= DELTA;
          else lvl <= lvl - 1'b1;
        end
        DELTA: begin
          cur   <= cur_c;
          neg   <= delta < 18'sd0;
          mag   <= 16'((delta < 18'sd0) ? -delta : delta);
          state <= SCALE;
        end
        SCALE: begin
          scaled <= prod[23:8];
          state  <= WRAP;
        end
        WRAP: begin
          target <= damped_c;
          low    <= '0;
          high   <= high_init;
          mid    <= high_init >> 1;
          state  <= (high_init != '0) ? SRCH : NLOW;
        end
        SRCH: begin
          low  <= low_n;
          high <= high_n;
          mid  <= mid_n;
          if (!(low_n < high_n)) state <= NLOW;
        end
        NLOW: begin
          key_low <= rdata;
          if (low != '0) begin
            state <= NPREV;
          end else begin
            done       <= 1'b1;
            best_slot  <= best_ext[11:0];
            damped_key <= target;
            state      <= IDLE;
            busy       <= 1'b0;
          end
        end
        NPREV: begin
          done       <= 1'b1;
          best_slot  <= (d_prev < d_low) ? prev_ext[11:0] : best_ext[11:0];
          damped_key <= target;
          state      <= IDLE;
          busy       <= 1'b0;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == SRCH) |-> (low < high))
    else $error("search bounds crossed");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == dhss_pkg::CMD_QUERY && has_target) |=> busy)
    else $error("targeted query did not start");

  a_no_target: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == dhss_pkg::CMD_QUERY && !has_target)
      |=> (done && best_slot == $past(slot) && damped_key == '0))
    else $error("no-target query result wrong");

  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == dhss_pkg::CMD_WRITE) |=> (!done && !busy))
    else $error("key write produced activity");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the damped Hilbert slot search core. Runs a short
// directed table of requests, register settings and a sorted key table fill,
// then random segments with sorted tables of random size under random
// register values. Query results are compared against values given in the rows,
// the no-target rule or an in-bench Hilbert / damping / nearest-key predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import dhss_pkg::*;

  localparam int MAX_SLOTS   = 4096;
  localparam int MAX_ORDER   = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYC  = 30;
  localparam int PHASE_REQS  = 500;
  localparam int SEG_REQS    = 40;

  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               has_target;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] best;
    logic [KEY_W-1:0]  dkey;
  } hit_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CFG, ROW_FILL} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]  reg_val;
    req_t              rq;
    logic              typed;
    hit_t              want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                cmd = CMD_WRITE;
  logic [SLOT_W-1:0]   slot = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [COORD_W-1:0]  target_col = '0;
  logic [COORD_W-1:0]  target_row = '0;
  logic                has_target = 1'b0;
  logic                done;
  logic [SLOT_W-1:0]   best_slot;
  logic [KEY_W-1:0]    damped_key;
  logic                cfg_write = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  // bench copy of the block state
  logic [KEY_W-1:0]  key_mem [0:MAX_SLOTS-1];
  logic [CNT_W-1:0]  cnt_reg = SLOT_COUNT_RST;
  logic [ORD_W-1:0]  ord_reg = CURVE_ORDER_RST;
  logic [DAMP_W-1:0] damp_reg = DAMPING_RST;

  hit_t expected_hits [$];
  row_t dir_rows [$];
  hit_t head;
  int   err_count = 0;
  int   cycle_count = 0;
  int   idle_pct = 35;

  always #5 clk = ~clk;

  damped_hilbert_slot_search_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .slot       (slot),
    .key        (key),
    .target_col (target_col),
    .target_row (target_row),
    .has_target (has_target),
    .done       (done),
    .best_slot  (best_slot),
    .damped_key (damped_key),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int eff_slots();
    if (cnt_reg < 1) return 1;
    if (cnt_reg > MAX_SLOTS) return MAX_SLOTS;
    return cnt_reg;
  endfunction

  function automatic int eff_order();
    if (ord_reg < 1) return 1;
    if (ord_reg > MAX_ORDER) return MAX_ORDER;
    return ord_reg;
  endfunction

  function automatic hit_t predict_search(logic [SLOT_W-1:0] cur_slot,
                                          logic [COORD_W-1:0] col,
                                          logic [COORD_W-1:0] row);
    int   side, total, cur, tgt, x, y, s, rx, ry, t;
    int   delta, dmp, mag, damped, lo, hi, mid, kv, d_lo, d_hi;
    hit_t h;
    side  = 1 << eff_order();
    total = side * side;
    cur   = key_mem[cur_slot];
    cur   = cur & (total - 1);
    x     = col & (side - 1);
    y     = row & (side - 1);
    tgt   = 0;
    for (s = side / 2; s > 0; s = s / 2) begin
      rx  = ((x & s) != 0) ? 1 : 0;
      ry  = ((y & s) != 0) ? 1 : 0;
      tgt = tgt + s * s * ((3 * rx) ^ ry);
      if (ry == 0) begin
        if (rx == 1) begin
          x = side - 1 - x;
          y = side - 1 - y;
        end
        t = x;
        x = y;
        y = t;
      end
    end
    delta = tgt - cur;
    if (delta > total / 2) delta = delta - total;
    if (delta < -(total / 2)) delta = delta + total;
    dmp = damp_reg;
    if (dmp > 256) dmp = 256;
    mag = ((delta < 0) ? -delta : delta) * dmp / 256;
    damped = cur + ((delta < 0) ? -mag : mag);
    if (damped < 0) damped = damped + total;
    if (damped >= total) damped = damped - total;
    // lower bound, then nearer of found slot and its lower neighbor
    lo = 0;
    hi = eff_slots() - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      kv  = key_mem[mid];
      if (kv < damped) lo = mid + 1;
      else hi = mid;
    end
    if (lo > 0) begin
      kv   = key_mem[lo - 1];
      d_lo = (kv > damped) ? kv - damped : damped - kv;
      kv   = key_mem[lo];
      d_hi = (kv > damped) ? kv - damped : damped - kv;
      if (d_lo < d_hi) lo = lo - 1;
    end
    h.best = lo[SLOT_W-1:0];
    h.dkey = damped[KEY_W-1:0];
    return h;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 100) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_req(input req_t rq, input logic typed, input hit_t want);
    hit_t h;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    @(negedge clk);
    cmd        <= rq.cmd;
    slot       <= rq.slot;
    key        <= rq.key;
    target_col <= rq.col;
    target_row <= rq.row;
    has_target <= rq.has_target;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rq.cmd == CMD_WRITE) begin
      key_mem[rq.slot] = rq.key;
    end else begin
      if (typed) begin
        h = want;
      end else if (!rq.has_target) begin
        h.best = rq.slot;
        h.dkey = '0;
      end else begin
        h = predict_search(rq.slot, rq.col, rq.row);
      end
      expected_hits.push_back(h);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SLOT_COUNT:  cnt_reg = val[CNT_W-1:0];
      REG_CURVE_ORDER: ord_reg = val[ORD_W-1:0];
      REG_DAMPING:     damp_reg = val[DAMP_W-1:0];
      default: ;
    endcase
  endtask

  // rewrite slots 0..count-1 with a nondecreasing random key sequence
  task automatic load_sorted();
    int   n, total, stepmax, k;
    req_t rq;
    n       = eff_slots();
    total   = 1 << (2 * eff_order());
    stepmax = (2 * total) / n;
    if (stepmax < 1) stepmax = 1;
    k = $urandom_range(0, stepmax);
    for (int i = 0; i < n; i++) begin
      if (k > total - 1) k = total - 1;
      rq.cmd        = CMD_WRITE;
      rq.slot       = i;
      rq.key        = k;
      rq.col        = $urandom_range(0, 255);
      rq.row        = $urandom_range(0, 255);
      rq.has_target = $urandom_range(0, 1);
      send_req(rq, 1'b0, '0);
      k = k + $urandom_range(0, stepmax);
    end
  endtask

  function automatic void add_req(logic c, int s, int k, int cl, int rw, logic ht,
                                  logic ty, int es, int ek);
    row_t r;
    r               = '0;
    r.kind          = ROW_REQ;
    r.rq.cmd        = c;
    r.rq.slot       = s;
    r.rq.key        = k;
    r.rq.col        = cl;
    r.rq.row        = rw;
    r.rq.has_target = ht;
    r.typed         = ty;
    r.want.best     = es;
    r.want.dkey     = ek;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [IDX_W-1:0] idx, int val);
    row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d key %0d",
                                  best_slot, damped_key));
      end else begin
        head = expected_hits.pop_front();
        if (best_slot !== head.best)
          report_mismatch($sformatf("best_slot %0d, want %0d", best_slot, head.best));
        if (damped_key !== head.dkey)
          report_mismatch($sformatf("damped_key %0d, want %0d", damped_key, head.dkey));
      end
    end
  end

  initial begin : main
    row_t r;
    req_t rq;
    int   p, served;

    for (int i = 0; i < MAX_SLOTS; i++) key_mem[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no-target answers straight after reset
    add_req(CMD_QUERY, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0);
    add_req(CMD_QUERY, 4095, 65535, 255, 255, 1'b0, 1'b1, 4095, 0);
    r      = '0;
    r.kind = ROW_FILL;
    dir_rows.push_back(r);
    // grid corners and other points on a full table with keys in steps of 16
    add_req(CMD_QUERY, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0);
    add_req(CMD_QUERY, 4095, 0, 255, 0, 1'b1, 1'b1, 4095, 65535);
    add_req(CMD_QUERY, 0, 0, 255, 0, 1'b1, 1'b0, 0, 0);
    add_req(CMD_QUERY, 2048, 0, 128, 128, 1'b1, 1'b0, 0, 0);
    add_req(CMD_QUERY, 17, 0, 3, 250, 1'b1, 1'b0, 0, 0);
    // register saturation
    add_cfg(REG_SLOT_COUNT, 0);
    add_req(CMD_QUERY, 7, 0, 3, 9, 1'b1, 1'b0, 0, 0);
    add_cfg(REG_SLOT_COUNT, 8191);
    add_cfg(REG_CURVE_ORDER, 0);
    add_req(CMD_QUERY, 4095, 0, 255, 254, 1'b1, 1'b0, 0, 0);
    add_cfg(REG_CURVE_ORDER, 15);
    add_cfg(REG_DAMPING, 511);
    add_req(CMD_QUERY, 1000, 0, 37, 201, 1'b1, 1'b0, 0, 0);
    add_cfg(REG_DAMPING, 0);
    add_req(CMD_QUERY, 1000, 0, 200, 10, 1'b1, 1'b0, 0, 0);
    add_cfg(REG_DAMPING, 128);
    add_cfg(REG_CURVE_ORDER, 3);
    add_req(CMD_QUERY, 3, 0, 7, 7, 1'b1, 1'b0, 0, 0);
    add_req(CMD_QUERY, 4095, 0, 0, 7, 1'b1, 1'b0, 0, 0);
    add_cfg(REG_SLOT_COUNT, 2);
    add_req(CMD_QUERY, 1, 0, 5, 2, 1'b1, 1'b0, 0, 0);
    add_req(CMD_WRITE, 4095, 65535, 0, 0, 1'b0, 1'b0, 0, 0);
    add_cfg(REG_SLOT_COUNT, SLOT_COUNT_RST);
    add_cfg(REG_CURVE_ORDER, CURVE_ORDER_RST);
    add_cfg(REG_DAMPING, DAMPING_RST);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      case (r.kind)
        ROW_CFG: begin
          settle();
          write_reg(r.reg_idx, r.reg_val);
        end
        ROW_FILL: begin
          for (int j = 0; j < MAX_SLOTS; j++) begin
            rq            = '0;
            rq.cmd        = CMD_WRITE;
            rq.slot       = j;
            rq.key        = (j == MAX_SLOTS - 1) ? 16'hFFFF : j * 16;
            rq.has_target = j[0];
            send_req(rq, 1'b0, '0);
          end
        end
        default: send_req(r.rq, r.typed, r.want);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 35 : (ph == 1) ? 52 : 0;
      served   = 0;
      while (served < PHASE_REQS) begin
        settle();
        case ($urandom_range(0, 9))
          0:       write_reg(REG_SLOT_COUNT, 0);
          1:       write_reg(REG_SLOT_COUNT, 1);
          2:       write_reg(REG_SLOT_COUNT, 2);
          3, 4:    write_reg(REG_SLOT_COUNT, $urandom_range(3, 16));
          5, 6, 7,
          8:       write_reg(REG_SLOT_COUNT, $urandom_range(17, 256));
          default: begin
            case ($urandom_range(0, 2))
              0:       write_reg(REG_SLOT_COUNT, MAX_SLOTS);
              1:       write_reg(REG_SLOT_COUNT, $urandom_range(4097, 8191));
              default: write_reg(REG_SLOT_COUNT, $urandom_range(257, 4095));
            endcase
          end
        endcase
        write_reg(REG_CURVE_ORDER, $urandom_range(0, 15));
        case ($urandom_range(0, 5))
          0:       write_reg(REG_DAMPING, 0);
          1:       write_reg(REG_DAMPING, DAMP_ONE);
          2:       write_reg(REG_DAMPING, $urandom_range(257, 511));
          default: write_reg(REG_DAMPING, $urandom_range(1, 255));
        endcase
        load_sorted();
        repeat (SEG_REQS) begin
          p       = $urandom_range(0, 99);
          rq.slot = $urandom_range(0, 4095);
          rq.key  = $urandom_range(0, 65535);
          rq.col  = $urandom_range(0, 255);
          rq.row  = $urandom_range(0, 255);
          if (p < 8) begin
            rq.cmd        = CMD_WRITE;
            rq.has_target = $urandom_range(0, 1);
          end else begin
            rq.cmd        = CMD_QUERY;
            rq.has_target = (p >= 18);
            if (p >= 18 && p < 90) rq.slot = $urandom_range(0, eff_slots() - 1);
          end
          send_req(rq, 1'b0, '0);
        end
        served = served + SEG_REQS;
      end
    end

    settle();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dhss_pkg.sv
src/damped_hilbert_slot_search_core.sv
tb/sv/tb_top.sv
